/* src/in_order_watermark_reorder_unit_defines.svh */
// assertion macros for the in-order watermark reorder unit
`ifndef IN_ORDER_WATERMARK_REORDER_UNIT_DEFINES_SVH
`define IN_ORDER_WATERMARK_REORDER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define IOWR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define IOWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/iowr_pkg.sv */
// types and constants shared by the watermark reorder unit
`default_nettype none

package iowr_pkg;

  localparam int Depth = 64;
  localparam int IdxW  = $clog2(Depth);
  localparam int TsW   = 64;
  localparam int SeqW  = 64;
  localparam int CntW  = 7;

  localparam logic [SeqW-1:0] SeqMax = '1;

  typedef enum logic [1:0] {
    DropNone   = 2'd0,
    DropStale  = 2'd1,
    DropBeyond = 2'd2
  } drop_e;

  typedef enum logic {
    StIdle,
    StDrain
  } state_e;

  typedef struct packed {
    logic [TsW-1:0]  timestamp;
    logic [SeqW-1:0] sequence_req;
  } in_req_t;

  typedef struct packed {
    logic [TsW-1:0]  watermark;
    logic [SeqW-1:0] applied_sequence;
    logic            synchronized;
    logic [CntW-1:0] pending_count;
    logic [1:0]      drop_status;
  } out_rsp_t;

  // controls driven into the cell row
  typedef struct packed {
    logic            shift;
    logic            wr;
    logic [IdxW-1:0] wr_idx;
    logic [TsW-1:0]  wr_ts;
  } chain_ctl_t;

  // status seen back from the cell row
  typedef struct packed {
    logic           head_valid;
    logic [TsW-1:0] head_ts;
    logic           wr_hit;
  } chain_sts_t;

endpackage

`default_nettype wire

/* src/iowr_cell.sv */
// one window cell: holds a pending update and hands it down the row
`default_nettype none

module iowr_cell (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     wr_i,
  input  wire logic [iowr_pkg::TsW-1:0] wr_ts_i,
  input  wire logic                     shift_i,
  input  wire logic                     nxt_valid_i,
  input  wire logic [iowr_pkg::TsW-1:0] nxt_ts_i,
  output logic                          valid_o,
  output logic [iowr_pkg::TsW-1:0]      ts_o
);

  logic                     valid_q, valid_d;
  logic [iowr_pkg::TsW-1:0] ts_q, ts_d;

  always_comb begin
    valid_d = valid_q;
    ts_d    = ts_q;
    if (wr_i) begin
      valid_d = 1'b1;
      ts_d    = wr_ts_i;
    end else if (shift_i) begin
      valid_d = nxt_valid_i;
      ts_d    = nxt_ts_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ts_q <= ts_d;
  end

  assign valid_o = valid_q;
  assign ts_o    = ts_q;

endmodule

`default_nettype wire

/* src/iowr_chain.sv */
// row of window cells, cell k holds sequence last_applied + 1 + k
`default_nettype none

module iowr_chain (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire iowr_pkg::chain_ctl_t  ctl_i,
  output iowr_pkg::chain_sts_t       sts_o
);

  logic [iowr_pkg::Depth-1:0] valid;
  logic [iowr_pkg::Depth-1:0] wr_sel;
  logic [iowr_pkg::TsW-1:0]   ts [iowr_pkg::Depth];

  for (genvar k = 0; k < iowr_pkg::Depth; k++) begin : g_cell
    logic                     nxt_valid;
    logic [iowr_pkg::TsW-1:0] nxt_ts;

    if (k == iowr_pkg::Depth - 1) begin : g_tail
      // a fresh empty slot enters at the far end
      assign nxt_valid = 1'b0;
      assign nxt_ts    = '0;
    end else begin : g_mid
      assign nxt_valid = valid[k+1];
      assign nxt_ts    = ts[k+1];
    end

    assign wr_sel[k] = ctl_i.wr && (ctl_i.wr_idx == iowr_pkg::IdxW'(k));

    iowr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_i        (wr_sel[k]),
      .wr_ts_i     (ctl_i.wr_ts),
      .shift_i     (ctl_i.shift),
      .nxt_valid_i (nxt_valid),
      .nxt_ts_i    (nxt_ts),
      .valid_o     (valid[k]),
      .ts_o        (ts[k])
    );
  end

  assign sts_o.head_valid = valid[0];
  assign sts_o.head_ts    = ts[0];
  // duplicate number: target cell already pending
  assign sts_o.wr_hit     = |(valid & wr_sel);

endmodule

`default_nettype wire

/* src/in_order_watermark_reorder_unit.sv */
// top level: request check, drain control and result register over the cell row
// a dropped request gives its result strobe in the cycle after acceptance, busy stays low
// an accepted request inserts at acceptance, then drains one update per cycle from the
// head cell until the head is empty or the applied sequence is at its maximum, busy
// stays high throughout, and the result strobe is registered as the drain ends
// rst_ni clears watermark, applied sequence, pending count and all cell valid bits
`default_nettype none

module in_order_watermark_reorder_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire iowr_pkg::in_req_t req_i,
  output logic                   rsp_valid_o,
  output iowr_pkg::out_rsp_t     rsp_o
);

  iowr_pkg::state_e          state_q, state_d;
  logic [iowr_pkg::TsW-1:0]  wm_q, wm_d;
  logic [iowr_pkg::SeqW-1:0] last_q, last_d;
  logic [iowr_pkg::CntW-1:0] pend_q, pend_d;
  logic                      rsp_valid_q, rsp_valid_d;
  iowr_pkg::out_rsp_t        rsp_q, rsp_d;

  iowr_pkg::chain_ctl_t      ctl;
  iowr_pkg::chain_sts_t      sts;

  logic                      accept;
  logic                      stale;
  logic                      beyond;
  logic [iowr_pkg::SeqW-1:0] diff;
  logic [iowr_pkg::SeqW-1:0] diff_m1;

  assign busy   = (state_q == iowr_pkg::StDrain);
  assign accept = start && !busy;

  assign diff    = req_i.sequence_req - last_q;
  assign diff_m1 = diff - iowr_pkg::SeqW'(1);
  assign stale   = (req_i.sequence_req <= last_q);
  assign beyond  = !stale && (diff > iowr_pkg::SeqW'(iowr_pkg::Depth));

  always_comb begin
    state_d     = state_q;
    wm_d        = wm_q;
    last_d      = last_q;
    pend_d      = pend_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;

    ctl.shift  = 1'b0;
    ctl.wr     = 1'b0;
    ctl.wr_idx = diff_m1[iowr_pkg::IdxW-1:0];
    ctl.wr_ts  = req_i.timestamp;

    rsp_d.watermark        = wm_q;
    rsp_d.applied_sequence = last_q;
    rsp_d.synchronized     = (pend_q == '0);
    rsp_d.pending_count    = pend_q;
    rsp_d.drop_status      = iowr_pkg::DropNone;

    case (state_q)
      iowr_pkg::StIdle: begin
        if (accept) begin
          if (stale || beyond) begin
            rsp_d.drop_status = stale ? iowr_pkg::DropStale : iowr_pkg::DropBeyond;
            rsp_valid_d       = 1'b1;
          end else begin
            ctl.wr = 1'b1;
            if (!sts.wr_hit) begin
              pend_d = pend_q + iowr_pkg::CntW'(1);
            end
            state_d = iowr_pkg::StDrain;
          end
        end
      end
      iowr_pkg::StDrain: begin
        if (sts.head_valid && (last_q != iowr_pkg::SeqMax)) begin
          // apply the head update and move the window up by one
          ctl.shift = 1'b1;
          wm_d      = sts.head_ts;
          last_d    = last_q + iowr_pkg::SeqW'(1);
          if (pend_q != '0) begin
            pend_d = pend_q - iowr_pkg::CntW'(1);
          end
        end else begin
          rsp_valid_d = 1'b1;
          state_d     = iowr_pkg::StIdle;
        end
      end
      default: begin
        state_d = iowr_pkg::StIdle;
      end
    endcase
  end

  iowr_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .sts_o  (sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iowr_pkg::StIdle;
      wm_q        <= '0;
      last_q      <= '0;
      pend_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wm_q        <= wm_d;
      last_q      <= last_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

/* src/iowr_checker.sv */
// port-level checks for the watermark reorder unit, bound to the top level
`default_nettype none

`include "in_order_watermark_reorder_unit_defines.svh"

module iowr_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               rsp_valid_o,
  input wire iowr_pkg::out_rsp_t rsp_o
);

  // a result only follows a request or the end of a drain
  `IOWR_ASSERT_IMPL(a_no_spurious_rsp, rsp_valid_o, $past(busy) || $past(start && !busy), "result strobe without a request")

  // an accepted request either drains or reports a drop at once
  `IOWR_ASSERT_NEXT(a_req_progress, start && !busy, busy || rsp_valid_o, "request neither drained nor answered")

  `IOWR_ASSERT_IMPL(a_sync_matches_count, rsp_valid_o, rsp_o.synchronized == (rsp_o.pending_count == '0), "synchronized flag disagrees with pending count")

  `IOWR_ASSERT_IMPL(a_status_code, rsp_valid_o, rsp_o.drop_status == iowr_pkg::DropNone || rsp_o.drop_status == iowr_pkg::DropStale || rsp_o.drop_status == iowr_pkg::DropBeyond, "unknown drop status")

  // every result reports a pending count inside the window
  `IOWR_ASSERT_IMPL(a_count_bound, rsp_valid_o, rsp_o.pending_count <= iowr_pkg::CntW'(iowr_pkg::Depth), "pending count beyond window")

endmodule

bind in_order_watermark_reorder_unit iowr_checker u_iowr_checker (.*);

`default_nettype wire

/* tb/in_order_watermark_reorder_unit_tb.sv */
// self-checking testbench for the in-order watermark reorder unit
`timescale 1ns / 100ps

module in_order_watermark_reorder_unit_tb;

  localparam int WdLimit  = 4000;
  localparam int TailWait = 150;
  localparam int PhaseLen = 400;

  typedef struct {
    iowr_pkg::in_req_t req;
    int unsigned       idle_pct;
  } wm_item_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  iowr_pkg::in_req_t  req = '0;
  logic               rsp_valid_o;
  iowr_pkg::out_rsp_t rsp_o;

  in_order_watermark_reorder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  // pending requests and the results they are predicted to give
  wm_item_t           update_q[$];
  iowr_pkg::out_rsp_t wm_result_q[$];

  // shadow of the reorder window
  logic [iowr_pkg::TsW-1:0]  shadow_wm = '0;
  logic [iowr_pkg::SeqW-1:0] shadow_seq = '0;
  logic [iowr_pkg::TsW-1:0]  shadow_ts[iowr_pkg::Depth];
  logic                      shadow_vld[iowr_pkg::Depth];
  int unsigned               shadow_pend = 0;

  logic [iowr_pkg::SeqW-1:0] gen_last = '0;
  int unsigned               gen_cnt = 0;
  int unsigned               err_cnt = 0;
  int unsigned               n_ok = 0, n_stale = 0, n_beyond = 0, max_pend = 0;
  int unsigned               quiet_cycles = 0;
  iowr_pkg::out_rsp_t        mon_exp;
  int unsigned               phase_pct[4] = '{0, 53, 0, 19};

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < iowr_pkg::Depth; i++) begin
      shadow_vld[i] = 1'b0;
      shadow_ts[i]  = '0;
    end
  end

  function automatic iowr_pkg::out_rsp_t predict_update(iowr_pkg::in_req_t r);
    iowr_pkg::out_rsp_t        o;
    iowr_pkg::drop_e           st;
    int                        idx;
    logic [iowr_pkg::SeqW-1:0] nxt;
    if (r.sequence_req <= shadow_seq) begin
      st = iowr_pkg::DropStale;
    end else if (r.sequence_req - shadow_seq > iowr_pkg::SeqW'(iowr_pkg::Depth)) begin
      st = iowr_pkg::DropBeyond;
    end else begin
      st  = iowr_pkg::DropNone;
      idx = int'(r.sequence_req % iowr_pkg::Depth);
      if (!shadow_vld[idx]) begin
        shadow_vld[idx] = 1'b1;
        shadow_pend++;
      end
      shadow_ts[idx] = r.timestamp;
      // apply every in-order update now sitting at the head
      for (int n = 0; n < iowr_pkg::Depth; n++) begin
        if (shadow_seq == iowr_pkg::SeqMax) break;
        nxt = shadow_seq + 1;
        idx = int'(nxt % iowr_pkg::Depth);
        if (!shadow_vld[idx]) break;
        shadow_wm       = shadow_ts[idx];
        shadow_seq      = nxt;
        shadow_vld[idx] = 1'b0;
        if (shadow_pend > 0) shadow_pend--;
      end
    end
    o.watermark        = shadow_wm;
    o.applied_sequence = shadow_seq;
    o.synchronized     = (shadow_pend == 0);
    o.pending_count    = iowr_pkg::CntW'(shadow_pend);
    o.drop_status      = st;
    return o;
  endfunction

  task automatic push_update(input logic [iowr_pkg::TsW-1:0] ts,
                             input logic [iowr_pkg::SeqW-1:0] seq,
                             input int unsigned pct);
    wm_item_t it;
    it.req.timestamp    = ts;
    it.req.sequence_req = seq;
    it.idle_pct         = pct;
    update_q.push_back(it);
    gen_cnt++;
  endtask

  function automatic logic [iowr_pkg::TsW-1:0] rand_ts();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // out-of-window, stale or wild sequence numbers around the current base
  function automatic logic [iowr_pkg::SeqW-1:0] noise_seq(logic [iowr_pkg::SeqW-1:0] base);
    case ($urandom_range(4, 0))
      0:       return iowr_pkg::SeqW'($urandom_range(32'(base), 0));
      1:       return base + iowr_pkg::SeqW'(iowr_pkg::Depth)
                      + iowr_pkg::SeqW'($urandom_range(3, 0));
      2:       return iowr_pkg::SeqMax - iowr_pkg::SeqW'($urandom_range(3, 0));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one run of consecutive numbers, shuffled or descending, with duplicates and noise mixed in
  task automatic gen_window_run(input int unsigned pct);
    logic [iowr_pkg::SeqW-1:0] seqs[$];
    logic [iowr_pkg::SeqW-1:0] tmp;
    int unsigned               w;
    int unsigned               j;
    bit                        desc;
    w    = ($urandom_range(7, 0) == 0) ? iowr_pkg::Depth : $urandom_range(16, 1);
    desc = (w == iowr_pkg::Depth) || ($urandom_range(3, 0) == 0);
    for (int unsigned i = 1; i <= w; i++) begin
      if (desc) seqs.push_back(gen_last + iowr_pkg::SeqW'(w - i + 1));
      else seqs.push_back(gen_last + iowr_pkg::SeqW'(i));
    end
    if (!desc) begin
      for (int i = seqs.size() - 1; i > 0; i--) begin
        j       = $urandom_range(i, 0);
        tmp     = seqs[i];
        seqs[i] = seqs[j];
        seqs[j] = tmp;
      end
    end
    for (int i = 0; i < seqs.size(); i++) begin
      if ($urandom_range(99, 0) < 15) push_update(rand_ts(), noise_seq(gen_last), pct);
      push_update(rand_ts(), seqs[i], pct);
      if ($urandom_range(99, 0) < 10) push_update(rand_ts(), seqs[$urandom_range(i, 0)], pct);
    end
    gen_last += iowr_pkg::SeqW'(w);
  endtask

  task automatic cmp_field(input string fname, input logic [63:0] exp_v,
                           input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", fname, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // driver: one request presented at a time, held until taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) wm_result_q.push_back(predict_update(req));
      if (!start || !busy) begin
        if (update_q.size() != 0 && $urandom_range(99, 0) >= update_q[0].idle_pct) begin
          start <= 1'b1;
          req   <= update_q[0].req;
          update_q.delete(0);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) begin
      if (wm_result_q.size() == 0) begin
        $error("result with no request outstanding: seq %0h", rsp_o.applied_sequence);
        err_cnt++;
      end else begin
        mon_exp = wm_result_q.pop_front();
        cmp_field("watermark", mon_exp.watermark, rsp_o.watermark);
        cmp_field("applied_sequence", mon_exp.applied_sequence, rsp_o.applied_sequence);
        cmp_field("synchronized", 64'(mon_exp.synchronized), 64'(rsp_o.synchronized));
        cmp_field("pending_count", 64'(mon_exp.pending_count), 64'(rsp_o.pending_count));
        cmp_field("drop_status", 64'(mon_exp.drop_status), 64'(rsp_o.drop_status));
        case (iowr_pkg::drop_e'(mon_exp.drop_status))
          iowr_pkg::DropNone:   n_ok++;
          iowr_pkg::DropStale:  n_stale++;
          iowr_pkg::DropBeyond: n_beyond++;
          default:              ;
        endcase
        if (mon_exp.pending_count > max_pend) max_pend = mon_exp.pending_count;
      end
    end
  end

  // watchdog on cycles with neither a request taken nor a result
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || rsp_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WdLimit) begin
        $display("timeout: no progress for %0d cycles", WdLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    // directed: stale, window edges, duplicates, extreme numbers and timestamps
    push_update(64'h1234_5678_9abc_def0, '0, 0);
    push_update('1, 64'd1, 0);
    push_update('0, 64'd1, 0);
    push_update(64'hdead_beef, 64'd66, 0);
    push_update('0, 64'd65, 0);
    push_update('1, 64'd65, 0);
    push_update(64'h5555_5555_5555_5555, iowr_pkg::SeqMax, 0);
    push_update(64'haaaa_aaaa_aaaa_aaaa, {32'h8000_0000, 32'h0}, 0);
    push_update(64'h0f0f, 64'd3, 0);
    push_update(64'hf0f0, 64'd3, 0);
    push_update('0, 64'd2, 0);
    push_update('1, 64'd0, 0);
    push_update(64'h77, 64'd4, 0);
    gen_last = 64'd4;

    for (int p = 0; p < 4; p++) begin
      gen_cnt = 0;
      while (gen_cnt < PhaseLen) gen_window_run(phase_pct[p]);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (update_q.size() != 0 || start) @(posedge clk_i);
    while (wm_result_q.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);

    if (wm_result_q.size() != 0) begin
      $error("%0d predicted results never arrived", wm_result_q.size());
      err_cnt++;
    end
    $display("covered %0d applied-path, %0d stale and %0d out-of-window requests",
             n_ok, n_stale, n_beyond);
    $display("deepest window occupancy %0d, last applied sequence %0d", max_pend, shadow_seq);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/iowr_pkg.sv
src/iowr_cell.sv
src/iowr_chain.sv
src/in_order_watermark_reorder_unit.sv
src/iowr_checker.sv
tb/in_order_watermark_reorder_unit_tb.sv
